### design/tme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tme_pkg: shared types for the tape machine executor
// Opcodes, status codes and the command that travels from front to back.
// ----------------------------------------------------------------------------
package tme_pkg;

	typedef enum logic [3:0] {
		OP_RIGHT      = 4'd0,
		OP_LEFT       = 4'd1,
		OP_ADD_CELL   = 4'd2,
		OP_ADD_HEAD   = 4'd3,
		OP_WRITE_CHAR = 4'd4,
		OP_READ_CHAR  = 4'd5,
		OP_LOOP_OPEN  = 4'd6,
		OP_LOOP_CLOSE = 4'd7,
		OP_CLEAR      = 4'd8
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LEFT_ERR = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// what the back end does with the cell under the head
	typedef enum logic [2:0] {
		CELL_NONE,
		CELL_ADD,
		CELL_LOAD,
		CELL_PRINT,
		CELL_BR_ZERO,
		CELL_BR_NONZERO
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [7:0] operand;
		status_t    status;
	} cell_cmd_t;

	localparam int unsigned CMD_W = $bits(cell_cmd_t);

endpackage

### design/tme_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tme_front: instruction intake and head pointer
// Accepts instructions, updates the head and issues cell commands.
// ----------------------------------------------------------------------------
module tme_front import tme_pkg::*; #(
	parameter int unsigned TAPE_DEPTH = 4096,
	parameter int unsigned AW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [3:0]    req_type,
	input  logic [15:0]   amount,
	input  logic [7:0]    in_byte,
	input  logic          in_end,
	input  logic          busy,
	input  logic          q_full,
	output logic          push,
	output logic [AW-1:0] push_addr,
	output cell_cmd_t     push_cmd
);

	localparam int unsigned SW = ((AW > 16) ? AW : 16) + 2;
	localparam logic [AW-1:0] LAST = AW'(TAPE_DEPTH - 1);

	logic [AW-1:0]        head_q;
	logic [AW-1:0]        head_d;
	logic signed [SW-1:0] hsum;

	assign in_stall  = busy | q_full;
	assign push      = in_valid & ~in_stall;
	assign push_addr = head_q;

	assign hsum = $signed({{(SW-AW){1'b0}}, head_q}) + $signed({{(SW-16){amount[15]}}, amount});

	always_comb begin
		head_d           = head_q;
		push_cmd.op      = CELL_NONE;
		push_cmd.operand = 8'd0;
		push_cmd.status  = ST_OK;
		unique case (req_type)
			OP_RIGHT: begin
				if (head_q == LAST) begin
					push_cmd.status = ST_OVERFLOW;
				end else begin
					head_d = head_q + 1'b1;
				end
			end
			OP_LEFT: begin
				if (head_q == '0) begin
					push_cmd.status = ST_LEFT_ERR;
				end else begin
					head_d = head_q - 1'b1;
				end
			end
			OP_ADD_HEAD: begin
				// clamp at zero, saturate at the last cell
				if (hsum[SW-1]) begin
					head_d = '0;
				end else if (hsum > $signed({{(SW-AW){1'b0}}, LAST})) begin
					head_d          = LAST;
					push_cmd.status = ST_OVERFLOW;
				end else begin
					head_d = hsum[AW-1:0];
				end
			end
			OP_ADD_CELL: begin
				push_cmd.op      = CELL_ADD;
				push_cmd.operand = amount[7:0];
			end
			OP_READ_CHAR: begin
				push_cmd.op      = CELL_LOAD;
				push_cmd.operand = in_end ? 8'd0 : in_byte;
			end
			OP_CLEAR: begin
				push_cmd.op = CELL_LOAD;
			end
			OP_WRITE_CHAR: push_cmd.op = CELL_PRINT;
			OP_LOOP_OPEN:  push_cmd.op = CELL_BR_ZERO;
			OP_LOOP_CLOSE: push_cmd.op = CELL_BR_NONZERO;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (push) begin
			head_q <= head_d;
		end
	end

endmodule

### design/tme_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tme_queue: two-entry command queue
// Decouples the head logic from the tape pipeline.
// ----------------------------------------------------------------------------
module tme_queue #(
	parameter int unsigned W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         q_valid,
	output logic         q_full,
	output logic [W-1:0] q_data
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign q_valid = (count_q != 2'd0);
	assign q_full  = (count_q == 2'd2);
	assign q_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### design/tme_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tme_back: tape memory and cell pipeline
// Clears the tape after reset, then reads, updates and reports cells.
// ----------------------------------------------------------------------------
module tme_back import tme_pkg::*; #(
	parameter int unsigned TAPE_DEPTH = 4096,
	parameter int unsigned AW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [AW-1:0] q_addr,
	input  cell_cmd_t     q_cmd,
	output logic          pop,
	output logic          busy,
	output logic          res_valid,
	input  logic          res_stall,
	output logic [7:0]    out_byte,
	output logic          out_valid,
	output logic          take_branch,
	output logic [1:0]    status
);

	localparam logic [AW-1:0] LAST = AW'(TAPE_DEPTH - 1);

	logic [7:0]    tape_mem [TAPE_DEPTH];

	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	logic          v_s1;
	logic [AW-1:0] addr_s1;
	cell_cmd_t     cmd_s1;
	logic [7:0]    rdata_s1;
	logic          adv_s1;

	logic          fwd_v_q;
	logic [AW-1:0] fwd_addr_q;
	logic [7:0]    fwd_data_q;

	logic [7:0]    cur_byte;
	logic [7:0]    cell_new;
	logic          cell_wr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;

	logic          res_v_q;
	logic [7:0]    byte_q;
	logic          pv_q;
	logic          br_q;
	status_t       st_q;

	assign busy   = clearing_q;
	assign adv_s1 = v_s1 & (~res_v_q | ~res_stall);
	assign pop    = q_valid & ~clearing_q & (~v_s1 | adv_s1);

	// latest write wins over the registered read
	assign cur_byte = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata_s1;

	always_comb begin
		cell_new = cur_byte;
		cell_wr  = 1'b0;
		unique case (cmd_s1.op)
			CELL_ADD: begin
				cell_new = cur_byte + cmd_s1.operand;
				cell_wr  = 1'b1;
			end
			CELL_LOAD: begin
				cell_new = cmd_s1.operand;
				cell_wr  = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = 8'd0;
		end else begin
			mem_we    = adv_s1 & cell_wr;
			mem_waddr = addr_s1;
			mem_wdata = cell_new;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tape_mem[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			rdata_s1 <= tape_mem[q_addr];
			addr_s1  <= q_addr;
			cmd_s1   <= q_cmd;
		end
		if (mem_we) begin
			fwd_addr_q <= mem_waddr;
			fwd_data_q <= mem_wdata;
		end
		if (adv_s1) begin
			byte_q <= (cmd_s1.op == CELL_PRINT) ? cur_byte : 8'd0;
			pv_q   <= (cmd_s1.op == CELL_PRINT);
			br_q   <= ((cmd_s1.op == CELL_BR_ZERO) && (cur_byte == 8'd0)) ||
			          ((cmd_s1.op == CELL_BR_NONZERO) && (cur_byte != 8'd0));
			st_q   <= cmd_s1.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			v_s1       <= 1'b0;
			fwd_v_q    <= 1'b0;
			res_v_q    <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST) begin
					clearing_q <= 1'b0;
				end
			end
			if (mem_we) begin
				fwd_v_q <= 1'b1;
			end
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				res_v_q <= 1'b1;
			end else if (!res_stall) begin
				res_v_q <= 1'b0;
			end
		end
	end

	assign res_valid   = res_v_q;
	assign out_byte    = byte_q;
	assign out_valid   = pv_q;
	assign take_branch = br_q;
	assign status      = st_q;

endmodule

### design/tape_machine_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_machine_executor: execute unit of a byte-tape machine
// Head pointer, byte tape and one result transaction per instruction.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the tape to zero, one cell per cycle, and
// holds in_stall high until the whole tape is cleared, before it takes its first
// instruction. From then on it takes one instruction transaction per cycle
// while the command queue is not full, and returns one result transaction
// for each, in order; each result passes through the command queue, the
// cell read stage and the result register. The front end owns the
// head pointer and resolves moves, clamps and status at intake; cell work
// (add, load, clear, print, loop test) goes through a two-entry queue to the
// back end, where a tape memory with one read and one write port, a
// registered read and a one-entry write bypass handles back-to-back
// read-modify-write on the same cell. The result register lets a new
// instruction enter while a finished result waits to be taken.
// ----------------------------------------------------------------------------
module tape_machine_executor import tme_pkg::*; #(
	parameter int unsigned TAPE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// instruction transaction
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  req_type,
	input  logic [15:0] amount,
	input  logic [7:0]  in_byte,
	input  logic        in_end,
	// result transaction
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        take_branch,
	output logic [1:0]  status
);

	localparam int unsigned AW = $clog2(TAPE_DEPTH);
	localparam int unsigned QW = AW + CMD_W;

	logic          busy;
	logic          q_full;
	logic          q_valid;
	logic          push;
	logic          pop;
	logic [AW-1:0] push_addr;
	cell_cmd_t     push_cmd;
	logic [QW-1:0] q_data;
	logic [AW-1:0] q_addr;
	cell_cmd_t     q_cmd;

	// head handling and instruction classification
	tme_front #(
		.TAPE_DEPTH(TAPE_DEPTH),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.amount(amount),
		.in_byte(in_byte),
		.in_end(in_end),
		.busy(busy),
		.q_full(q_full),
		.push(push),
		.push_addr(push_addr),
		.push_cmd(push_cmd)
	);

	// cell commands carry the head address they apply to
	tme_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_addr, push_cmd}),
		.pop(pop),
		.q_valid(q_valid),
		.q_full(q_full),
		.q_data(q_data)
	);

	assign q_addr = q_data[QW-1:CMD_W];
	assign q_cmd  = cell_cmd_t'(q_data[CMD_W-1:0]);

	// tape memory, clearing sweep and result register
	tme_back #(
		.TAPE_DEPTH(TAPE_DEPTH),
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_addr(q_addr),
		.q_cmd(q_cmd),
		.pop(pop),
		.busy(busy),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_byte(out_byte),
		.out_valid(out_valid),
		.take_branch(take_branch),
		.status(status)
	);

endmodule

### design/tme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tme_checker: port-level checks for the tape machine executor
// Result consistency and result handshake rules.
// ----------------------------------------------------------------------------
module tme_checker import tme_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [7:0]  out_byte,
	input logic        out_valid,
	input logic        take_branch,
	input logic [1:0]  status
);

	// the clearing sweep holds off instructions right after reset
	a_reset_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall)
		else $error("instruction side open during tape clearing");

	// stalled result stays up with the same payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(status))
		else $error("result changed while stalled");

	// a print never branches and never reports a head error
	a_print_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_valid |-> !take_branch && status == ST_OK)
		else $error("print result carries branch or status");

	// only a print carries a nonzero byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_byte == 8'd0)
		else $error("byte without print");

	// loop results never report head errors
	a_branch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && take_branch |-> status == ST_OK)
		else $error("branch with head status");

endmodule

bind tape_machine_executor tme_checker u_tme_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.out_byte(out_byte),
	.out_valid(out_valid),
	.take_branch(take_branch),
	.status(status)
);
